[hdl/indexed_list_engine_defines.svh]
// Assertion helpers used by the list engine datapath module.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define ILE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ile_pkg.sv]
package ile_pkg;

    localparam int MODE_W  = 3;
    localparam int POS_W   = 11;
    localparam int VAL_W   = 32;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 3'd0,
        MODE_FRONT = 3'd1,
        MODE_BACK  = 3'd2,
        MODE_POS   = 3'd3,
        MODE_RM    = 3'd4
    } t_ile_mode;

    // Where an insert or removal lands.
    typedef enum logic [1:0] {
        TGT_FRONT,
        TGT_BACK,
        TGT_POS
    } t_ile_tgt;

    // Direction of the tail shift.
    typedef enum logic {
        DIR_INS,
        DIR_RM
    } t_ile_dir;

    // Source of the result value.
    typedef enum logic [1:0] {
        RSEL_ZERO,
        RSEL_MISS,
        RSEL_DATA
    } t_ile_rsel;

    typedef struct packed {
        logic      done;
        logic      full;
        t_ile_rsel rsel;
    } t_ile_res;

    typedef struct packed {
        logic     cap;
        t_ile_tgt tgt;
        t_ile_dir dir;
        logic     len_inc;
        logic     len_dec;
        logic     rd_tgt;
        logic     rd_step;
        logic     wr_shift;
        logic     wr_put;
        logic     out_load;
        t_ile_res res;
    } t_ile_cmd;

    typedef struct packed {
        logic pos_lt_len;
        logic pos_le_len;
        logic pos1_lt_len;
        logic len_zero;
        logic full;
        logic last_rd;
        logic out_free;
    } t_ile_status;

endpackage

[hdl/ile_dpath.sv]
`include "indexed_list_engine_defines.svh"

module ile_dpath #(
    parameter int CAPACITY = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ile_pkg::POS_W-1:0]  i_position,
    input  logic [ile_pkg::VAL_W-1:0]  i_value,
    input  ile_pkg::t_ile_cmd          i_cmd,
    output ile_pkg::t_ile_status       o_status,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic [ile_pkg::VAL_W-1:0]  o_read_value,
    output logic                       o_done_res,
    output logic                       o_full_drop
);
    import ile_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;
    logic [VAL_W-1:0] r_val;
    logic [LW-1:0]    r_len;
    logic [IW-1:0]    r_addr;
    logic [IW-1:0]    r_wr_addr;
    logic [IW-1:0]    r_stop;
    logic [IW-1:0]    r_tgt;
    t_ile_dir         r_dir;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    logic             r_out_done;
    logic             r_out_full;

    logic [CW-1:0]    pos_x;
    logic [CW-1:0]    len_x;
    logic [IW-1:0]    pos_i;
    logic [IW-1:0]    len_m1;
    logic [IW-1:0]    tgt_idx;
    logic [IW-1:0]    rd_addr;
    logic             rd_en;
    logic [IW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             wr_en;

    assign pos_x  = CW'(i_position);
    assign len_x  = CW'(r_len);
    assign pos_i  = IW'(i_position);
    assign len_m1 = IW'(r_len - LW'(1));

    always_comb begin
        o_status.pos_lt_len  = pos_x < len_x;
        o_status.pos_le_len  = pos_x <= len_x;
        o_status.pos1_lt_len = (pos_x + CW'(1)) < len_x;
        o_status.len_zero    = r_len == '0;
        o_status.full        = r_len == LW'(CAPACITY);
        o_status.last_rd     = r_addr == r_stop;
        o_status.out_free    = !r_out_valid || i_m_tready;
    end

    always_comb begin
        unique case (i_cmd.tgt)
            TGT_FRONT: tgt_idx = '0;
            TGT_BACK:  tgt_idx = r_len[IW-1:0];
            TGT_POS:   tgt_idx = pos_i;
            default:   tgt_idx = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.len_inc) begin
            r_len <= r_len + LW'(1);
        end else if (i_cmd.len_dec) begin
            r_len <= r_len - LW'(1);
        end
    end

    // Insert walks the tail downward from the last entry, removal walks it upward.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_val <= i_value;
            r_tgt <= tgt_idx;
            r_dir <= i_cmd.dir;
            if (i_cmd.dir == DIR_INS) begin
                r_addr <= len_m1;
                r_stop <= tgt_idx;
            end else begin
                r_addr <= pos_i + IW'(1);
                r_stop <= len_m1;
            end
        end else if (i_cmd.rd_step) begin
            if (r_dir == DIR_INS) begin
                r_addr    <= r_addr - IW'(1);
                r_wr_addr <= r_addr + IW'(1);
            end else begin
                r_addr    <= r_addr + IW'(1);
                r_wr_addr <= r_addr - IW'(1);
            end
        end
    end

    assign rd_en   = i_cmd.rd_tgt || i_cmd.rd_step;
    assign rd_addr = i_cmd.rd_tgt ? r_tgt : r_addr;
    assign wr_en   = i_cmd.wr_shift || i_cmd.wr_put;
    assign wr_addr = i_cmd.wr_put ? r_tgt : r_wr_addr;
    assign wr_data = i_cmd.wr_put ? r_val : r_rdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_done <= i_cmd.res.done;
            r_out_full <= i_cmd.res.full;
            unique case (i_cmd.res.rsel)
                RSEL_ZERO: r_out_value <= '0;
                RSEL_MISS: r_out_value <= '1;
                RSEL_DATA: r_out_value <= r_rdata;
                default:   r_out_value <= '0;
            endcase
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_done_res   = r_out_done;
    assign o_full_drop  = r_out_full;

    `ILE_ASSERT_IMP(a_len_bound, 1'b1, r_len <= LW'(CAPACITY), "list length above capacity")
    `ILE_ASSERT_IMP(a_one_write, 1'b1, !(i_cmd.wr_shift && i_cmd.wr_put), "two memory writes")
    `ILE_ASSERT_NEXT(a_len_inc, i_cmd.len_inc, r_len == $past(r_len) + LW'(1), "length not grown")
    `ILE_ASSERT_IMP(a_out_free, i_cmd.out_load, !r_out_valid || i_m_tready, "result overwritten")

endmodule

[hdl/ile_ctrl.sv]
module ile_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [ile_pkg::MODE_W-1:0] i_mode,
    input  ile_pkg::t_ile_status       i_status,
    output ile_pkg::t_ile_cmd          o_cmd
);
    import ile_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_OUT
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_ile_res r_res;
    t_ile_res n_res;
    logic     r_wr_pend;
    logic     n_wr_pend;
    logic     r_ins;
    logic     n_ins;
    logic     accept;
    logic     ins_ok;
    logic     ins_shift;
    t_ile_tgt ins_tgt;

    assign o_s_tready = r_state == S_IDLE;
    assign accept     = i_s_tvalid && (r_state == S_IDLE);

    always_comb begin
        ins_ok    = (i_mode != MODE_POS) || i_status.pos_le_len;
        ins_tgt   = TGT_BACK;
        ins_shift = 1'b0;
        if (i_mode == MODE_FRONT) begin
            ins_tgt   = TGT_FRONT;
            ins_shift = !i_status.len_zero;
        end else if (i_mode == MODE_POS) begin
            ins_tgt   = TGT_POS;
            ins_shift = i_status.pos_lt_len;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        n_wr_pend = r_wr_pend;
        n_ins     = r_ins;
        o_cmd     = '0;
        o_cmd.res = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res   = '{done: 1'b0, full: 1'b0, rsel: RSEL_ZERO};
                    n_state = S_OUT;
                    o_cmd.tgt = TGT_POS;
                    unique case (i_mode) inside
                        MODE_READ: begin
                            o_cmd.cap = 1'b1;
                            if (i_status.pos_lt_len) begin
                                n_res.done = 1'b1;
                                n_res.rsel = RSEL_DATA;
                                n_state    = S_RD;
                            end else begin
                                n_res.rsel = RSEL_MISS;
                            end
                        end
                        MODE_FRONT, MODE_BACK, MODE_POS: begin
                            if (ins_ok && i_status.full) begin
                                n_res.full = 1'b1;
                            end else if (ins_ok) begin
                                o_cmd.cap     = 1'b1;
                                o_cmd.tgt     = ins_tgt;
                                o_cmd.dir     = DIR_INS;
                                o_cmd.len_inc = 1'b1;
                                n_res.done    = 1'b1;
                                n_ins         = 1'b1;
                                n_wr_pend     = 1'b0;
                                n_state       = ins_shift ? S_SHIFT : S_PUT;
                            end
                        end
                        MODE_RM: begin
                            if (i_status.pos_lt_len) begin
                                o_cmd.cap     = 1'b1;
                                o_cmd.dir     = DIR_RM;
                                o_cmd.len_dec = 1'b1;
                                n_res.done    = 1'b1;
                                n_ins         = 1'b0;
                                n_wr_pend     = 1'b0;
                                n_state       = i_status.pos1_lt_len ? S_SHIFT : S_OUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd_tgt = 1'b1;
                n_state      = S_OUT;
            end
            S_SHIFT: begin
                // The entry read in the previous cycle is written while the next one is read.
                o_cmd.rd_step  = 1'b1;
                o_cmd.wr_shift = r_wr_pend;
                n_wr_pend      = 1'b1;
                if (i_status.last_rd) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.wr_shift = 1'b1;
                n_wr_pend      = 1'b0;
                n_state        = r_ins ? S_PUT : S_OUT;
            end
            S_PUT: begin
                o_cmd.wr_put = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wr_pend <= 1'b0;
            r_ins     <= 1'b0;
            r_res     <= '{done: 1'b0, full: 1'b0, rsel: RSEL_ZERO};
        end else begin
            r_state   <= n_state;
            r_wr_pend <= n_wr_pend;
            r_ins     <= n_ins;
            r_res     <= n_res;
        end
    end

endmodule

[hdl/indexed_list_engine.sv]
// A read goes through a store read and then the result register; an ignored request
// goes straight to the result register. An insert or removal first walks the tail,
// reading and writing one store entry per cycle; an insert then writes its new value.
// One request is handled at a time; the next transfer is taken once the result is queued.
// Synchronous active-low reset empties the list and clears control; the entry store
// itself is not cleared and holds no valid data until written.
module indexed_list_engine #(
    parameter int CAPACITY = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // [2:0] mode, [13:3] position, [45:14] value, [47:46] zero
    input  logic [ile_pkg::IN_W-1:0]   i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // [31:0] read_value, [32] done_res, [33] full_drop, [39:34] zero
    output logic [ile_pkg::OUT_W-1:0]  o_m_tdata
);
    import ile_pkg::*;

    t_ile_cmd         cmd;
    t_ile_status      status;
    logic [VAL_W-1:0] read_value;
    logic             done_res;
    logic             full_drop;

    ile_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_mode     (i_s_tdata[MODE_W-1:0]),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ile_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_position   (i_s_tdata[MODE_W +: POS_W]),
        .i_value      (i_s_tdata[MODE_W+POS_W +: VAL_W]),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_read_value (read_value),
        .o_done_res   (done_res),
        .o_full_drop  (full_drop)
    );

    assign o_m_tdata = {(OUT_W-VAL_W-2)'(0), full_drop, done_res, read_value};

endmodule

[dv/list_checker.sv]
module list_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    // [2:0] mode, [13:3] position, [45:14] value, [47:46] zero
    input  logic [ile_pkg::IN_W-1:0]   i_s_tdata,
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    // [31:0] read_value, [32] done_res, [33] full_drop, [39:34] zero
    input  logic [ile_pkg::OUT_W-1:0]  i_m_tdata,
    output int                         o_err_count,
    output int                         o_pending,
    output int                         o_list_len
);
    timeunit 1ns;
    timeprecision 1ps;
    import ile_pkg::*;

    // Same bit layout as the result tdata.
    typedef struct packed {
        logic [5:0]  pad;
        logic        full_drop;
        logic        done_res;
        logic [31:0] read_value;
    } t_list_reply;

    logic [31:0] list_mem [CAPACITY];
    int          list_len;
    t_list_reply reply_q [$];

    function automatic t_list_reply apply_request(logic [2:0] mode, logic [10:0] pos,
                                                  logic [31:0] val);
        t_list_reply r;
        logic        do_insert;
        int          at;
        r         = '0;
        do_insert = 1'b0;
        at        = 0;
        case (mode)
            MODE_READ: begin
                if (pos < list_len) begin
                    r.read_value = list_mem[pos];
                    r.done_res   = 1'b1;
                end else begin
                    r.read_value = '1;
                end
            end
            MODE_FRONT: begin
                do_insert = 1'b1;
                at        = 0;
            end
            MODE_BACK: begin
                do_insert = 1'b1;
                at        = list_len;
            end
            MODE_POS: begin
                if (pos <= list_len) begin
                    do_insert = 1'b1;
                    at        = pos;
                end
            end
            MODE_RM: begin
                if (pos < list_len) begin
                    for (int i = pos; i < list_len - 1; i++) begin
                        list_mem[i] = list_mem[i+1];
                    end
                    list_len--;
                    r.done_res = 1'b1;
                end
            end
            default: ;
        endcase
        if (do_insert) begin
            if (list_len >= CAPACITY) begin
                r.full_drop = 1'b1;
            end else begin
                for (int i = list_len; i > at; i--) begin
                    list_mem[i] = list_mem[i-1];
                end
                list_mem[at] = val;
                list_len++;
                r.done_res = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [39:0] want, logic [39:0] got);
        o_err_count++;
        $display("checker: %s: expected %h, got %h at %0t", what, want, got, $realtime);
    endtask

    always @(posedge i_clk) begin
        t_list_reply want;
        t_list_reply got;
        if (!i_rst_n) begin
            list_len = 0;
            reply_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                reply_q.push_back(apply_request(i_s_tdata[2:0], i_s_tdata[13:3],
                                                i_s_tdata[45:14]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (reply_q.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding", '0, got);
                end else begin
                    want = reply_q.pop_front();
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", want, got);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", want, got);
                    if (got.full_drop !== want.full_drop)
                        report_mismatch("full_drop", want, got);
                    if (got.pad !== want.pad)
                        report_mismatch("padding bits", want, got);
                end
            end
        end
        o_pending  <= reply_q.size();
        o_list_len <= list_len;
    end

endmodule

[dv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ile_pkg::*;

    localparam int          LIST_CAP       = 1024;
    localparam int          RANDOM_ITEMS   = 580;
    localparam int          CYCLE_LIMIT    = 2_500_000;
    localparam int          MAX_POS        = 2047;
    localparam logic [2:0]  MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0]  MODE_SPARE_MID = 3'd6;
    localparam logic [2:0]  MODE_SPARE_HI  = 3'd7;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    int err_count;
    int pending;
    int list_len;
    int burst_left = 0;
    int cycle_count = 0;

    indexed_list_engine #(
        .CAPACITY(LIST_CAP)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    list_checker #(
        .CAPACITY(LIST_CAP)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_list_len  (list_len)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // The result side switches at random between stall styles.
    int       rx_left  = 0;
    int       rx_style = 0;
    int       rx_tick  = 0;

    always @(negedge clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 3);
            rx_left  <= $urandom_range(16, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_tick % 4 == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Ends at the falling edge where the next request goes out; opens a gap
    // whenever the current burst is used up.
    task automatic next_slot();
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        burst_left--;
    endtask

    task automatic drive_req(logic [2:0] mode, logic [10:0] pos, logic [31:0] val);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, val, pos, mode};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic issue(logic [2:0] mode, logic [10:0] pos, logic [31:0] val);
        next_slot();
        drive_req(mode, pos, val);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat ($urandom_range(2, 12)) @(negedge clk);
        burst_left = 0;
    endtask

    // Mostly in-range requests; inserts give way to removals once the list is
    // long so that most tail shifts stay short.
    task automatic random_req();
        logic [2:0]  mode;
        logic [10:0] pos;
        logic [31:0] val;
        int          pick;
        next_slot();
        pick = $urandom_range(0, 99);
        if (pick < 3)       mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        else if (pick < 30) mode = MODE_READ;
        else if (pick < 42) mode = MODE_FRONT;
        else if (pick < 54) mode = MODE_BACK;
        else if (pick < 70) mode = MODE_POS;
        else                mode = MODE_RM;
        if (list_len > 48 && (mode == MODE_FRONT || mode == MODE_BACK || mode == MODE_POS)
            && $urandom_range(0, 1) == 1) begin
            mode = MODE_RM;
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)     pos = 11'($urandom_range(0, MAX_POS));
        else if (pick < 4) pos = 11'(list_len);
        else               pos = 11'($urandom_range(0, list_len + 1));
        pick = $urandom_range(0, 39);
        case (pick)
            0: val = 32'h8000_0000;
            1: val = 32'h7fff_ffff;
            2: val = 32'h0000_0000;
            3: val = 32'hffff_ffff;
            default: val = $urandom();
        endcase
        drive_req(mode, pos, val);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty list, out-of-range insert, then every way of inserting.
        issue(MODE_READ,  11'd0, 32'h0);
        issue(MODE_RM,    11'd0, 32'h0);
        issue(MODE_POS,   11'd1, 32'h1234_5678);
        issue(MODE_POS,   11'd0, 32'h7fff_ffff);
        issue(MODE_FRONT, 11'd0, 32'h8000_0000);
        issue(MODE_BACK,  11'd0, 32'hffff_ffff);
        issue(MODE_POS,   11'd3, 32'h0000_0000);
        issue(MODE_POS,   11'd2, 32'h5a5a_a5a5);
        for (int i = 0; i <= 5; i++) begin
            issue(MODE_READ, i[10:0], 32'h0);
        end
        issue(MODE_READ, MAX_POS[10:0], 32'hffff_ffff);
        issue(MODE_SPARE_LO, MAX_POS[10:0], 32'hffff_ffff);
        issue(MODE_SPARE_MID, MAX_POS[10:0], 32'hffff_ffff);
        issue(MODE_SPARE_HI, MAX_POS[10:0], 32'hffff_ffff);
        // Removals past the end, at the tail, at the head and in the middle.
        issue(MODE_RM,    11'd5, 32'h0);
        issue(MODE_RM,    MAX_POS[10:0], 32'h0);
        issue(MODE_RM,    11'd4, 32'h0);
        issue(MODE_RM,    11'd0, 32'h0);
        issue(MODE_RM,    11'd1, 32'h0);
        issue(MODE_READ,  11'd0, 32'h0);
        issue(MODE_READ,  11'd1, 32'h0);
        pause_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) pause_until_drained();
            random_req();
        end
        pause_until_drained();

        // Fill the store up to capacity by appends with a few reads mixed in.
        while (list_len < LIST_CAP) begin
            next_slot();
            if (list_len > 0 && $urandom_range(0, 15) == 0)
                drive_req(MODE_READ, 11'($urandom_range(0, list_len - 1)), $urandom());
            else
                drive_req(MODE_BACK, 11'($urandom_range(0, MAX_POS)), $urandom());
        end
        // Every insert into a full store is dropped unless its position is out of range.
        issue(MODE_FRONT, 11'd0, 32'h1111_1111);
        issue(MODE_BACK,  11'd0, 32'h2222_2222);
        issue(MODE_POS,   11'd0, 32'h3333_3333);
        issue(MODE_POS,   11'd512, 32'h4444_4444);
        issue(MODE_POS,   LIST_CAP[10:0], 32'h5555_5555);
        issue(MODE_POS,   11'(LIST_CAP + 1), 32'h6666_6666);
        issue(MODE_POS,   MAX_POS[10:0], 32'h7777_7777);
        issue(MODE_READ,  11'(LIST_CAP - 1), 32'h0);
        issue(MODE_READ,  LIST_CAP[10:0], 32'h0);
        issue(MODE_READ,  11'd0, 32'h0);
        issue(MODE_RM,    11'(LIST_CAP - 1), 32'h0);
        issue(MODE_POS,   11'(LIST_CAP - 1), 32'h8888_8888);
        issue(MODE_FRONT, 11'd0, 32'h9999_9999);
        issue(MODE_RM,    11'd0, 32'h0);
        issue(MODE_POS,   11'd0, 32'haaaa_aaaa);
        issue(MODE_READ,  11'd0, 32'h0);
        issue(MODE_READ,  11'(LIST_CAP - 1), 32'h0);
        for (int n = 0; n < 20; n++) begin
            random_req();
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (err_count == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
